@@ rtl/cpvg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpvg_pkg
// Shared constants and the quarter-wave sine table function.
// ----------------------------------------------------------------------------
package cpvg_pkg;

  localparam int SIDES_W = 6;
  localparam int MINR_W  = 23;
  localparam int TRIG_W  = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIDES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS = 2'd1;

  localparam logic [SIDES_W-1:0] SIDES_RESET = 6'd32;
  localparam logic [SIDES_W-1:0] SIDES_MIN   = 6'd3;
  localparam logic [MINR_W-1:0]  MINR_RESET  = 23'd0;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Quarter-wave entry k of a full turn of 2^ab steps, Q0.15, by a Taylor
  // series in Q30 arithmetic. Evaluated at elaboration only.
  function automatic logic [TRIG_W-1:0] qwave_f(input int unsigned k,
                                                 input int unsigned ab);
    longint unsigned quarter;
    longint unsigned x;
    longint unsigned t;
    longint          s;
    quarter = 64'd1 << (ab - 2);
    x = (PI_Q30 * longint'(k) + quarter) >> (ab - 1);
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      unique case (n)
        1: t = t / 6;
        2: t = t / 20;
        3: t = t / 42;
        4: t = t / 72;
        5: t = t / 110;
        6: t = t / 156;
        default: t = t / 210;
      endcase
      if (n % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    s = (s + 16384) >>> 15;
    if (s > 32767) s = 32767;
    return s[TRIG_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/circle_polygon_vertex_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_polygon_vertex_generator
// Regular polygon approximation of a circle from a center and perimeter point.
// ----------------------------------------------------------------------------
// A transaction is accepted on a clock edge with start high and busy low. The
// front stores the center and the absolute deltas in a two-entry queue, so up
// to two transactions can be taken while an earlier one is still producing
// vertices; busy is high only while that queue is full. The back computes the
// radius with a bit-serial square root and, in parallel, the phase step
// 2^ANGLE_BITS/sides with a bit-serial divider. It then emits sides+1
// vertices, or one rejection result if the radius is below min_radius.
// Each vertex after the first steps through the states RDS, RDC, MX, MY and
// OUT, set by the single sine table port and the shared multiplier. Results
// appear on vertex_x, vertex_y, last_vertex, status and saturated for exactly
// one cycle with vertex_strobe high; the receiver cannot stall them and must
// take every one.
// Configuration is written with cfg_we, cfg_index and cfg_data while no
// transaction is in flight; index 0 is sides (values below three act as
// three) and index 1 is min_radius; other indexes are ignored.
module circle_polygon_vertex_generator #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [COORD_BITS-1:0]   center_x,
  input  wire logic signed [COORD_BITS-1:0]   center_y,
  input  wire logic signed [COORD_BITS-1:0]   perimeter_x,
  input  wire logic signed [COORD_BITS-1:0]   perimeter_y,
  output logic                                vertex_strobe,
  output logic signed [COORD_BITS-1:0]        vertex_x,
  output logic signed [COORD_BITS-1:0]        vertex_y,
  output logic                                last_vertex,
  output logic                                status,
  output logic                                saturated,
  input  wire logic                           cfg_we,
  input  wire logic [cpvg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cpvg_pkg::MINR_W-1:0]    cfg_data
);
  import cpvg_pkg::*;

  localparam int QW = 4 * COORD_BITS;

  logic [SIDES_W-1:0] sides;
  logic [MINR_W-1:0]  min_radius;
  logic [SIDES_W-1:0] n_eff;

  logic          push;
  logic [QW-1:0] push_data;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          q_full;
  logic          q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sides      <= SIDES_RESET;
      min_radius <= MINR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SIDES) sides <= cfg_data[SIDES_W-1:0];
      else if (cfg_index == REG_MIN_RADIUS) min_radius <= cfg_data;
    end
  end

  // Degenerate side counts are treated as a triangle.
  assign n_eff = (sides < SIDES_MIN) ? SIDES_MIN : sides;
  assign busy  = q_full;

  cpvg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .start       (start),
    .center_x    (center_x),
    .center_y    (center_y),
    .perimeter_x (perimeter_x),
    .perimeter_y (perimeter_y),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  cpvg_fifo #(.W(QW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  cpvg_back #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .pop           (pop),
    .n_eff         (n_eff),
    .min_radius    (min_radius),
    .vertex_strobe (vertex_strobe),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .last_vertex   (last_vertex),
    .status        (status),
    .saturated     (saturated)
  );

endmodule
`default_nettype wire

@@ rtl/cpvg_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpvg_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module cpvg_fifo #(
  parameter int W = 96
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              full,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/cpvg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpvg_front
// Accepts a transaction and forms the absolute center-to-perimeter deltas.
// ----------------------------------------------------------------------------
module cpvg_front #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         start,
  input  wire logic signed [COORD_BITS-1:0] center_x,
  input  wire logic signed [COORD_BITS-1:0] center_y,
  input  wire logic signed [COORD_BITS-1:0] perimeter_x,
  input  wire logic signed [COORD_BITS-1:0] perimeter_y,
  input  wire logic                         q_full,
  output logic                              push,
  output logic [4*COORD_BITS-1:0]           push_data
);

  localparam int C = COORD_BITS;

  logic signed [C:0] dx;
  logic signed [C:0] dy;
  logic [C-1:0]      ax;
  logic [C-1:0]      ay;
  logic [C:0]        nx;
  logic [C:0]        ny;

  always_comb begin
    dx = (C+1)'(center_x) - (C+1)'(perimeter_x);
    dy = (C+1)'(center_y) - (C+1)'(perimeter_y);
    nx = -dx;
    ny = -dy;
    ax = dx[C] ? nx[C-1:0] : dx[C-1:0];
    ay = dy[C] ? ny[C-1:0] : dy[C-1:0];
  end

  assign push      = start && !q_full;
  assign push_data = {center_x, center_y, ax, ay};

endmodule
`default_nettype wire

@@ rtl/cpvg_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpvg_sqrt
// Floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module cpvg_sqrt #(
  parameter int RW = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2*RW-2:0] operand,
  output logic [RW-1:0]        root,
  output logic                 busy
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] val;
  logic [RW:0]     rem;
  logic [CW-1:0]   cnt;
  logic [RW+2:0]   remc;
  logic [RW+2:0]   cand;
  logic [RW+2:0]   diff;

  assign busy = (cnt != '0);

  always_comb begin
    remc = {rem, val[2*RW-1 -: 2]};
    cand = {1'b0, root, 2'b01};
    diff = remc - cand;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= {1'b0, operand};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val <= val << 2;
      if (remc >= cand) begin
        rem  <= diff[RW:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= remc[RW:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (start) cnt <= CW'(RW);
    else if (busy) cnt <= cnt - CW'(1);
  end

endmodule
`default_nettype wire

@@ rtl/cpvg_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpvg_back
// Radius, rejection test and the vertex sequencer with its sine table.
// ----------------------------------------------------------------------------
module cpvg_back #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_empty,
  input  wire logic [4*COORD_BITS-1:0]      q_data,
  output logic                              pop,
  input  wire logic [cpvg_pkg::SIDES_W-1:0] n_eff,
  input  wire logic [cpvg_pkg::MINR_W-1:0]  min_radius,
  output logic                              vertex_strobe,
  output logic signed [COORD_BITS-1:0]      vertex_x,
  output logic signed [COORD_BITS-1:0]      vertex_y,
  output logic                              last_vertex,
  output logic                              status,
  output logic                              saturated
);
  import cpvg_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int AB  = ANGLE_BITS;
  localparam int RW  = C + 1;
  localparam int SW  = C + 3;
  localparam int AW  = AB - 1;
  localparam int QN  = (1 << (AB - 2)) + 1;
  localparam int DCW = $clog2(AB + 2);
  localparam int MW  = (RW > MINR_W) ? RW : MINR_W;

  localparam logic [AW-1:0] QUARTER_A = {1'b1, {(AB-2){1'b0}}};
  localparam logic [AB-1:0] QUARTER_P = {2'b01, {(AB-2){1'b0}}};
  localparam logic [AB:0]   FULL_D    = {1'b1, {AB{1'b0}}};
  localparam logic signed [SW-1:0] CMAX = {4'b0000, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {4'b1111, {(C-1){1'b0}}};

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_SQ    = 4'd1;
  localparam logic [3:0] B_SUM   = 4'd2;
  localparam logic [3:0] B_ROOT  = 4'd3;
  localparam logic [3:0] B_V0    = 4'd4;
  localparam logic [3:0] B_RDS   = 4'd5;
  localparam logic [3:0] B_RDC   = 4'd6;
  localparam logic [3:0] B_MX    = 4'd7;
  localparam logic [3:0] B_MY    = 4'd8;
  localparam logic [3:0] B_OUT   = 4'd9;
  localparam logic [3:0] B_CLOSE = 4'd10;

  logic [3:0] state;

  logic signed [C-1:0] cx;
  logic signed [C-1:0] cy;
  logic [C-1:0]        ax;
  logic [C-1:0]        ay;
  logic [2*C-1:0]      sx;
  logic [2*C-1:0]      sy;
  logic [SIDES_W-1:0]  n;
  logic [SIDES_W-1:0]  idx;

  logic [AB:0]         dval;
  logic [SIDES_W-1:0]  drem;
  logic [AB-1:0]       dquo;
  logic [DCW-1:0]      dcnt;
  logic [SIDES_W:0]    dtry;

  logic [AB-1:0]       pq;
  logic [SIDES_W+1:0]  prem;
  logic [SIDES_W+1:0]  adv_sum;
  logic                adv_wrap;
  logic [AB-1:0]       pq_next;
  logic [SIDES_W+1:0]  prem_next;
  logic [AB-1:0]       step_q;
  logic [SIDES_W:0]    step_r;

  logic                sqrt_start;
  logic [RW-1:0]       r;
  logic                sqrt_busy;

  logic [TRIG_W-1:0]   qtab [QN];
  logic [AW-1:0]       rom_addr;
  logic [TRIG_W-1:0]   rom_data;
  logic [AB-1:0]       cph;

  logic                sin_neg;
  logic                cos_neg;
  logic [TRIG_W-1:0]   sin_mag;
  logic [TRIG_W-1:0]   cos_mag;
  logic [TRIG_W-1:0]   mul_b;
  logic [RW+TRIG_W-1:0] prod;
  logic signed [SW-1:0] term;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [SW-1:0] sum_0;
  logic [C-1:0]        vx;
  logic                satx;
  logic [C-1:0]        v0y;
  logic                v0sat;
  logic                reject;

  function automatic logic [C:0] clamp_f(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    logic                 s;
    c = v;
    s = 1'b0;
    if (v > CMAX) begin
      c = CMAX;
      s = 1'b1;
    end else if (v < CMIN) begin
      c = CMIN;
      s = 1'b1;
    end
    return {s, c[C-1:0]};
  endfunction

  function automatic logic [AW-1:0] taddr_f(input logic [AB-1:0] ph);
    logic [AW-1:0] k;
    k = {1'b0, ph[AB-3:0]};
    return ph[AB-2] ? (QUARTER_A - k) : k;
  endfunction

  for (genvar k = 0; k < QN; k++) begin : g_tab
    assign qtab[k] = qwave_f(k, AB);
  end

  cpvg_sqrt #(.RW(RW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .operand ({1'b0, sx} + {1'b0, sy}),
    .root    (r),
    .busy    (sqrt_busy)
  );

  assign pop        = (state == B_IDLE) && !q_empty;
  assign sqrt_start = (state == B_SUM);
  assign reject     = MW'(r) < MW'(min_radius);
  assign cph        = pq + QUARTER_P;
  assign dtry       = {drem, dval[AB]};

  always_comb begin
    adv_sum   = prem + (SIDES_W+2)'(step_r);
    adv_wrap  = adv_sum >= {1'b0, n, 1'b0};
    prem_next = adv_wrap ? adv_sum - {1'b0, n, 1'b0} : adv_sum;
    pq_next   = pq + step_q + AB'(adv_wrap);
  end

  always_comb begin
    unique case (state)
      B_RDC:   rom_addr = taddr_f(cph);
      default: rom_addr = taddr_f(pq);
    endcase
    mul_b = (state == B_MX) ? sin_mag : cos_mag;
    term  = SW'(prod[RW+TRIG_W-1:TRIG_W]);
    sum_x = SW'(cx) + (sin_neg ? -term : term);
    sum_y = SW'(cy) + (cos_neg ? -term : term);
    sum_0 = SW'(cy) + SW'(r);
  end

  always_ff @(posedge clk) begin
    rom_data <= qtab[rom_addr];
    prod     <= r * mul_b;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      {cx, cy, ax, ay} <= q_data;
      n <= n_eff;
    end
    if (state == B_SQ) begin
      sx <= ax * ax;
      sy <= ay * ay;
    end
    if (state == B_SUM) begin
      dval <= FULL_D;
      drem <= '0;
      dquo <= '0;
    end else if (dcnt != '0) begin
      dval <= dval << 1;
      if (dtry >= {1'b0, n}) begin
        drem <= SIDES_W'(dtry - {1'b0, n});
        dquo <= {dquo[AB-2:0], 1'b1};
      end else begin
        drem <= dtry[SIDES_W-1:0];
        dquo <= {dquo[AB-2:0], 1'b0};
      end
    end
    if (state == B_V0) begin
      step_q <= dquo;
      step_r <= {drem, 1'b0};
      pq     <= '0;
      prem   <= (SIDES_W+2)'(n);
      {v0sat, v0y} <= clamp_f(sum_0);
    end
    if (state == B_RDS) sin_neg <= pq[AB-1];
    if (state == B_RDC) begin
      cos_neg <= cph[AB-1];
      sin_mag <= rom_data;
    end
    if (state == B_MX) cos_mag <= rom_data;
    if (state == B_MY) {satx, vx} <= clamp_f(sum_x);
    if (state == B_OUT) begin
      pq   <= pq_next;
      prem <= prem_next;
    end
  end

  // The first phase step is taken in the cycle after vertex 0 is latched.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      dcnt          <= '0;
      idx           <= '0;
      vertex_strobe <= 1'b0;
    end else begin
      vertex_strobe <= 1'b0;
      if (state == B_SUM) dcnt <= DCW'(AB + 1);
      else if (dcnt != '0) dcnt <= dcnt - DCW'(1);
      unique case (state)
        B_IDLE: if (!q_empty) state <= B_SQ;
        B_SQ:   state <= B_SUM;
        B_SUM:  state <= B_ROOT;
        B_ROOT: if (!sqrt_busy && dcnt == '0) state <= B_V0;
        B_V0: begin
          vertex_strobe <= 1'b1;
          if (reject) begin
            vertex_x    <= cx;
            vertex_y    <= cy;
            last_vertex <= 1'b1;
            status      <= 1'b1;
            saturated   <= 1'b0;
            state       <= B_IDLE;
          end else begin
            vertex_x    <= cx;
            {saturated, vertex_y} <= clamp_f(sum_0);
            last_vertex <= 1'b0;
            status      <= 1'b0;
            idx         <= '0;
            state       <= B_OUT;
          end
        end
        B_RDS:  state <= B_RDC;
        B_RDC:  state <= B_MX;
        B_MX:   state <= B_MY;
        B_MY:   state <= B_OUT;
        B_OUT: begin
          // Entered once right after vertex 0 only to advance the phase.
          if (idx != '0) begin
            vertex_strobe <= 1'b1;
            vertex_x      <= vx;
            {saturated, vertex_y} <= clamp_f(sum_y) | {satx, {C{1'b0}}};
            last_vertex   <= 1'b0;
            status        <= 1'b0;
          end
          if (idx == n - SIDES_W'(1)) begin
            state <= B_CLOSE;
          end else begin
            idx   <= idx + SIDES_W'(1);
            state <= B_RDS;
          end
        end
        B_CLOSE: begin
          vertex_strobe <= 1'b1;
          vertex_x      <= cx;
          vertex_y      <= v0y;
          saturated     <= v0sat;
          last_vertex   <= 1'b1;
          status        <= 1'b0;
          state         <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    vertex_strobe && status |-> last_vertex)
    else $error("rejection result without last flag");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    vertex_strobe && last_vertex |-> state == B_IDLE)
    else $error("sequencer still running after final result");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == B_RDS |-> idx != '0 && idx < n)
    else $error("vertex index out of range");

  a_root_ready: assert property (@(posedge clk) disable iff (rst)
    state == B_V0 |-> !sqrt_busy && dcnt == '0)
    else $error("radius or phase step used before ready");

endmodule
`default_nettype wire

@@ sim/circle_polygon_vertex_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_polygon_vertex_generator_tb
// Self-checking bench: random and directed circles, vertex-by-vertex compare.
// ----------------------------------------------------------------------------
// A driver process presents circle transactions from a queue of pending
// circles. A monitor process predicts the full vertex list of every accepted
// transaction and compares each strobed vertex with the oldest prediction.
// Register writes happen only while the block is drained.
module circle_polygon_vertex_generator_tb;
  import cpvg_pkg::*;

  localparam int CW = 24;
  localparam int AB = 12;
  localparam int FULL_TURN = 1 << AB;
  localparam int QUARTER = FULL_TURN >> 2;
  localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (CW - 1));
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct {
    logic signed [CW-1:0] cx, cy, px, py;
  } circle_req_t;

  typedef struct {
    logic signed [CW-1:0] x, y;
    logic last, stat, sat;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] center_x = '0, center_y = '0, perimeter_x = '0, perimeter_y = '0;
  logic vertex_strobe;
  logic signed [CW-1:0] vertex_x, vertex_y;
  logic last_vertex, status, saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MINR_W-1:0] cfg_data = '0;

  circle_req_t pending_circles[$];
  vertex_t expected_vertices[$];
  int mismatch_count = 0;
  int gap_cnt = 0;
  bit idle_en = 1'b1;

  // Shadow copies of the registers and the quarter-wave table in Q1.15.
  logic [SIDES_W-1:0] sides_shadow;
  logic [MINR_W-1:0] min_radius_shadow;
  longint sine_q15[0:QUARTER];

  circle_polygon_vertex_generator #(.COORD_BITS(CW), .ANGLE_BITS(AB)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .center_x(center_x), .center_y(center_y),
    .perimeter_x(perimeter_x), .perimeter_y(perimeter_y),
    .vertex_strobe(vertex_strobe), .vertex_x(vertex_x), .vertex_y(vertex_y),
    .last_vertex(last_vertex), .status(status), .saturated(saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Each table entry is a Taylor series of sin(x) in Q30, up to x^15/15!,
  // with truncating steps, rounded to Q15 at the end.
  task automatic build_sine_table();
    longint unsigned x, t;
    longint s;
    for (int k = 0; k <= QUARTER; k++) begin
      x = (64'd3373259426 * longint'(k) + QUARTER) / (2 * QUARTER);
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      s = (s + 16384) >>> 15;
      if (s > 32767) s = 32767;
      sine_q15[k] = s;
    end
  endtask

  function automatic longint sine_of_phase(longint p);
    longint q, k;
    p = p & (FULL_TURN - 1);
    q = p >> (AB - 2);
    k = p & (QUARTER - 1);
    case (q)
      0: return sine_q15[k];
      1: return sine_q15[QUARTER - k];
      2: return -sine_q15[k];
      default: return -sine_q15[QUARTER - k];
    endcase
  endfunction

  // Product of radius and Q1.15 sine, truncated toward zero.
  function automatic longint radius_times(longint r, longint s);
    if (s < 0) return -((r * -s) >>> 15);
    return (r * s) >>> 15;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint root, cand;
    root = 0;
    for (int b = 26; b >= 0; b--) begin
      cand = root | (64'sd1 <<< b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  task automatic push_vertex(longint x, longint y, logic last, logic stat);
    vertex_t v;
    v.sat = 1'b0;
    if (x > COORD_MAX) begin x = COORD_MAX; v.sat = 1'b1; end
    if (x < COORD_MIN) begin x = COORD_MIN; v.sat = 1'b1; end
    if (y > COORD_MAX) begin y = COORD_MAX; v.sat = 1'b1; end
    if (y < COORD_MIN) begin y = COORD_MIN; v.sat = 1'b1; end
    v.x = x[CW-1:0];
    v.y = y[CW-1:0];
    v.last = last;
    v.stat = stat;
    expected_vertices.push_back(v);
  endtask

  // Expected vertex list of one circle under the current shadow registers.
  task automatic predict_polygon(circle_req_t c);
    longint cx, cy, dx, dy, r, n, p;
    cx = c.cx;
    cy = c.cy;
    dx = cx - longint'(c.px);
    dy = cy - longint'(c.py);
    r = floor_sqrt(dx * dx + dy * dy);
    n = (sides_shadow < SIDES_MIN) ? SIDES_MIN : sides_shadow;
    if (r < longint'(min_radius_shadow)) begin
      push_vertex(cx, cy, 1'b1, STATUS_REJECT);
    end else begin
      push_vertex(cx, cy + r, 1'b0, STATUS_OK);
      for (longint i = 1; i < n; i++) begin
        p = ((i * FULL_TURN * 2 + n) / (2 * n)) & (FULL_TURN - 1);
        push_vertex(cx + radius_times(r, sine_of_phase(p)),
                    cy + radius_times(r, sine_of_phase(p + QUARTER)), 1'b0, STATUS_OK);
      end
      push_vertex(cx, cy + r, 1'b1, STATUS_OK);
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Driver: new values go out on the falling edge; bursts of idle cycles
  // come at random while idle_en is set.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_cnt != 0) begin
      gap_cnt <= gap_cnt - 1;
      start <= 1'b0;
    end else if (pending_circles.size() != 0) begin
      if (idle_en && $urandom_range(0, 5) == 0) begin
        gap_cnt <= $urandom_range(0, 2);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        center_x <= pending_circles[0].cx;
        center_y <= pending_circles[0].cy;
        perimeter_x <= pending_circles[0].px;
        perimeter_y <= pending_circles[0].py;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: accepted transactions are predicted, strobed vertices checked.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst) begin
      if (start && !busy) begin
        predict_polygon(pending_circles.pop_front());
      end
      if (vertex_strobe) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch($sformatf("unexpected vertex (%0d, %0d)", vertex_x, vertex_y));
        end else begin
          e = expected_vertices.pop_front();
          if (vertex_x !== e.x)
            report_mismatch($sformatf("vertex_x %0d, want %0d", vertex_x, e.x));
          if (vertex_y !== e.y)
            report_mismatch($sformatf("vertex_y %0d, want %0d", vertex_y, e.y));
          if (last_vertex !== e.last)
            report_mismatch($sformatf("last_vertex %b, want %b", last_vertex, e.last));
          if (status !== e.stat)
            report_mismatch($sformatf("status %b, want %b", status, e.stat));
          if (saturated !== e.sat)
            report_mismatch($sformatf("saturated %b, want %b", saturated, e.sat));
        end
      end
    end
  end

  // Register writes mirror into the shadow copies; unused indexes are ignored.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MINR_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_SIDES) sides_shadow = data[SIDES_W-1:0];
    else if (idx == REG_MIN_RADIUS) min_radius_shadow = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The sender holds off here until every predicted vertex has come out.
  task automatic wait_drained();
    while (pending_circles.size() != 0 || expected_vertices.size() != 0 || busy)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_circle(longint cx, longint cy, longint px, longint py);
    circle_req_t c;
    c.cx = cx[CW-1:0];
    c.cy = cy[CW-1:0];
    c.px = px[CW-1:0];
    c.py = py[CW-1:0];
    pending_circles.push_back(c);
  endtask

  function automatic longint clip(longint v);
    return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
  endfunction

  // Mostly a random center with a nearby perimeter point; sometimes the
  // four coordinates are fully random so every bit toggles.
  task automatic add_random_circle();
    longint cx, cy, span;
    cx = longint'($signed($urandom_range(0, (1 << CW) - 1) << 8)) >>> 8;
    cy = longint'($signed($urandom_range(0, (1 << CW) - 1) << 8)) >>> 8;
    case ($urandom_range(0, 3))
      0: add_circle(cx, cy, $urandom, $urandom);
      1: span = 1 << 20;
      default: span = 4096;
    endcase
    if (pending_circles.size() == 0 || pending_circles[$].cx !== cx[CW-1:0])
      add_circle(cx, cy, clip(cx + $urandom_range(0, 2 * span) - span),
                 clip(cy + $urandom_range(0, 2 * span) - span));
  endtask

  initial begin
    logic [MINR_W-1:0] minr_set[7];
    logic [SIDES_W-1:0] sides_set[7];
    minr_set = '{23'd0, 23'h7FFFFF, 23'd0, 23'd2000, 23'd0, 23'd100000, 23'd1};
    sides_set = '{6'd3, 6'd63, 6'd0, 6'd7, 6'd1, 6'd2, 6'd12};
    sides_shadow = SIDES_RESET;
    min_radius_shadow = MINR_RESET;
    build_sine_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed circles at reset settings: zero radius, unit radius, axis
    // aligned, and corner-to-corner radii that force saturation.
    add_circle(0, 0, 0, 0);
    add_circle(5, -5, 6, -5);
    add_circle(-100, 7, -100, 1007);
    add_circle(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    add_circle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    add_circle(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    add_circle(0, COORD_MAX, 0, COORD_MAX - 1000);
    add_circle(1000, -1000, -2000, 3000);
    wait_drained();

    // Rejection just below and acceptance exactly at the minimum radius,
    // plus a write to an index that must be ignored.
    write_reg(REG_MIN_RADIUS, 23'd500);
    write_reg(REG_SPARE, 23'h7FFFFF);
    write_reg(REG_SIDES, 6'd5);
    add_circle(10, 10, 10, 509);
    add_circle(10, 10, 310, 410);
    add_circle(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_SIDES, sides_set[ph]);
      write_reg(REG_MIN_RADIUS, minr_set[ph]);
      if (ph == 6) idle_en = 1'b0;
      for (int k = 0; k < 19; k++) add_random_circle();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** circle_polygon_vertex_generator: PASSED **");
    end else begin
      $display("** circle_polygon_vertex_generator: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** circle_polygon_vertex_generator: FAILED **");
    $finish;
  end

endmodule
